// File: sv/rsz_pkg.sv
package rsz_pkg;

   localparam int MAX_DIM_DEFAULT          = 4096;
   localparam int SINE_TABLE_DEPTH_DEFAULT = 4096;
   localparam int WRAP_PASSES_DEFAULT      = 8;

   localparam int COORD_IN_W  = 12;
   localparam int FRAME_W     = 13;
   localparam int ANGLE_W     = 14;
   localparam int SINE_W      = 15;
   localparam int TRIG_W      = 16;
   localparam int MUL_W       = 17;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = 30;
   localparam int COORD_W     = 18;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam int QUARTER_UNITS = 4096;
   localparam int QUARTER_BITS  = 12;
   localparam int PRODUCT_SHIFT = 13;
   localparam int SCALE_SHIFT   = 15;
   localparam int ZOOM_BASE     = 8192;
   localparam int ZOOM_AMPL     = 8100;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 20;
   localparam logic [63:0] TAYLOR_DIVISOR [TAYLOR_TERMS] = '{
      64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
      64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056, 64'd1190,
      64'd1332, 64'd1482
   };

   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_ROTATE_STEP,
      REG_ZOOM_STEP,
      REG_START_ROTATE,
      REG_START_ZOOM
   } reg_index_type;

   typedef struct packed {
      logic [FRAME_W-1:0]        frame_width;
      logic [FRAME_W-1:0]        frame_height;
      logic signed [ANGLE_W-1:0] rotate_step;
      logic signed [ANGLE_W-1:0] zoom_step;
      logic [ANGLE_W-1:0]        start_rotate_angle;
      logic [ANGLE_W-1:0]        start_zoom_angle;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RD_ZOOM,
      OP_MUL_AMPL,
      OP_ZOOM,
      OP_MUL_COS,
      OP_MUL_SIN,
      OP_MUL_XC,
      OP_MUL_YS,
      OP_MUL_XS,
      OP_MUL_YC,
      OP_SUM_Y,
      OP_WRAP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: sv/rsz_csr.sv
module rsz_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rsz_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rsz_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rsz_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output rsz_pkg::cfg_type               cfg
);
   import rsz_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width        <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height       <= FRAME_HEIGHT_RESET;
         cfg_ff.rotate_step        <= '0;
         cfg_ff.zoom_step          <= '0;
         cfg_ff.start_rotate_angle <= '0;
         cfg_ff.start_zoom_angle   <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_FRAME_WIDTH:  cfg_ff.frame_width        <= csr_pwdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height       <= csr_pwdata[FRAME_W-1:0];
            REG_ROTATE_STEP:  cfg_ff.rotate_step        <= csr_pwdata[ANGLE_W-1:0];
            REG_ZOOM_STEP:    cfg_ff.zoom_step          <= csr_pwdata[ANGLE_W-1:0];
            REG_START_ROTATE: cfg_ff.start_rotate_angle <= csr_pwdata[ANGLE_W-1:0];
            REG_START_ZOOM:   cfg_ff.start_zoom_angle   <= csr_pwdata[ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_ROTATE_STEP:  csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.rotate_step));
         REG_ZOOM_STEP:    csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.zoom_step));
         REG_START_ROTATE: csr_prdata = CSR_DATA_W'(cfg_ff.start_rotate_angle);
         REG_START_ZOOM:   csr_prdata = CSR_DATA_W'(cfg_ff.start_zoom_angle);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// File: sv/rsz_ctrl.sv
module rsz_ctrl #(
   parameter int WRAP_PASSES = rsz_pkg::WRAP_PASSES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rsz_pkg::dp_status_type status,
   output rsz_pkg::dp_cmd_type    cmd
);
   import rsz_pkg::*;

   localparam int PASS_W = $clog2(WRAP_PASSES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_ZOOM,
      ST_MUL_AMPL,
      ST_ZOOM,
      ST_MUL_COS,
      ST_MUL_SIN,
      ST_MUL_XC,
      ST_MUL_YS,
      ST_MUL_XS,
      ST_MUL_YC,
      ST_SUM_Y,
      ST_WRAP,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [PASS_W-1:0] pass_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE:     if (req_tvalid) state_ff <= ST_RD_ZOOM;
            ST_RD_ZOOM:  state_ff <= ST_MUL_AMPL;
            ST_MUL_AMPL: state_ff <= ST_ZOOM;
            ST_ZOOM:     state_ff <= ST_MUL_COS;
            ST_MUL_COS:  state_ff <= ST_MUL_SIN;
            ST_MUL_SIN:  state_ff <= ST_MUL_XC;
            ST_MUL_XC:   state_ff <= ST_MUL_YS;
            ST_MUL_YS:   state_ff <= ST_MUL_XS;
            ST_MUL_XS:   state_ff <= ST_MUL_YC;
            ST_MUL_YC:   state_ff <= ST_SUM_Y;
            ST_SUM_Y: begin
               state_ff <= ST_WRAP;
               pass_ff  <= '0;
            end
            ST_WRAP: begin
               if (pass_ff == PASS_W'(WRAP_PASSES - 1)) begin
                  state_ff <= ST_EMIT;
               end else begin
                  pass_ff <= pass_ff + 1'b1;
               end
            end
            ST_EMIT:     if (status.out_free) state_ff <= ST_IDLE;
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE:     cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         ST_RD_ZOOM:  cmd.op = OP_RD_ZOOM;
         ST_MUL_AMPL: cmd.op = OP_MUL_AMPL;
         ST_ZOOM:     cmd.op = OP_ZOOM;
         ST_MUL_COS:  cmd.op = OP_MUL_COS;
         ST_MUL_SIN:  cmd.op = OP_MUL_SIN;
         ST_MUL_XC:   cmd.op = OP_MUL_XC;
         ST_MUL_YS:   cmd.op = OP_MUL_YS;
         ST_MUL_XS:   cmd.op = OP_MUL_XS;
         ST_MUL_YC:   cmd.op = OP_MUL_YC;
         ST_SUM_Y:    cmd.op = OP_SUM_Y;
         ST_WRAP:     cmd.op = OP_WRAP;
         ST_EMIT:     cmd.op = status.out_free ? OP_EMIT : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

// File: sv/rsz_dp.sv
module rsz_dp #(
   parameter int MAX_DIM          = rsz_pkg::MAX_DIM_DEFAULT,
   parameter int SINE_TABLE_DEPTH = rsz_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rsz_pkg::dp_cmd_type            cmd,
   output rsz_pkg::dp_status_type         status,
   input  rsz_pkg::cfg_type               cfg,
   input  logic [rsz_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [rsz_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import rsz_pkg::*;

   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int RIDX_W = QUARTER_BITS + 1 + IDX_W;

   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx);
      logic [63:0]        theta;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        q;
      theta = (64'(idx) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      t2    = (theta * theta) >> 30;
      term  = theta;
      sum   = signed'(theta);
      for (int k = 1; k < TAYLOR_TERMS; k++) begin
         if (term != 0) begin
            term = ((term * t2) >> 30) / TAYLOR_DIVISOR[k];
            if (k[0]) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (unsigned'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[SINE_W-1:0];
   endfunction

   function automatic logic signed [TRIG_W-1:0] trunc15(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] sh;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      sh  = mag >> SCALE_SHIFT;
      return p[PROD_W-1] ? -sh[TRIG_W-1:0] : sh[TRIG_W-1:0];
   endfunction

   function automatic logic [FRAME_W-1:0] clamp_size(input logic [FRAME_W-1:0] n);
      if (n < FRAME_W'(2)) begin
         return FRAME_W'(2);
      end else if (32'(n) > 32'(MAX_DIM)) begin
         return FRAME_W'(MAX_DIM);
      end
      return n;
   endfunction

   function automatic logic signed [COORD_W-1:0] wrap_pass(input logic signed [COORD_W-1:0] v,
                                                           input logic [FRAME_W-1:0] size);
      logic signed [COORD_W-1:0] s;
      s = $signed({{(COORD_W - FRAME_W){1'b0}}, size});
      if (v < 0) begin
         return v + s;
      end else if (v >= s) begin
         return v - s;
      end
      return v;
   endfunction

   function automatic logic [COORD_IN_W-1:0] saturate(input logic signed [COORD_W-1:0] v,
                                                      input logic [FRAME_W-1:0] size);
      logic signed [COORD_W-1:0] s;
      logic [COORD_W-1:0]        r;
      s = $signed({{(COORD_W - FRAME_W){1'b0}}, size});
      if (v < 0) begin
         r = '0;
      end else if (v >= s) begin
         r = unsigned'(s - COORD_W'(1));
      end else begin
         r = unsigned'(v);
      end
      return r[COORD_IN_W-1:0];
   endfunction

   logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
      assign sine_rom[g] = sine_entry(g);
   end

   logic [ANGLE_W-1:0]        rotate_angle_ff;
   logic [ANGLE_W-1:0]        zoom_angle_ff;
   logic [COORD_IN_W-1:0]     x_ff;
   logic [COORD_IN_W-1:0]     y_ff;
   logic                      last_ff;
   logic [SINE_W-1:0]         rom_ff;
   logic                      rom_neg_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [TRIG_W-1:0]  zoom_ff;
   logic signed [TRIG_W-1:0]  cos_ff;
   logic signed [TRIG_W-1:0]  c_ff;
   logic signed [TRIG_W-1:0]  s_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [COORD_W-1:0] ox_ff;
   logic signed [COORD_W-1:0] oy_ff;
   logic                      rsp_tvalid_ff;
   logic [COORD_IN_W-1:0]     rsp_x_ff;
   logic [COORD_IN_W-1:0]     rsp_y_ff;
   logic                      rsp_last_ff;

   logic [ANGLE_W-1:0]        rom_angle;
   logic [QUARTER_BITS:0]     quarter_off;
   logic [RIDX_W-1:0]         scaled_off;
   logic [IDX_W-1:0]          rom_idx;
   logic signed [TRIG_W-1:0]  rom_sv;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [ACC_W-1:0]   prod30;
   logic signed [ACC_W-1:0]   acc_shift;
   logic signed [ACC_W-1:0]   sum_y;
   logic signed [ACC_W-1:0]   sum_shift;
   logic signed [TRIG_W-1:0]  zoom_in;
   logic [FRAME_W-1:0]        size_x;
   logic [FRAME_W-1:0]        size_y;

   always_comb begin
      rom_angle = zoom_angle_ff;
      case (cmd.op) inside
         OP_MUL_AMPL:         rom_angle = rotate_angle_ff + ANGLE_W'(QUARTER_UNITS);
         OP_ZOOM, OP_MUL_COS: rom_angle = rotate_angle_ff;
         default:             rom_angle = zoom_angle_ff;
      endcase
   end

   assign quarter_off = rom_angle[QUARTER_BITS]
                      ? (QUARTER_BITS + 1)'(QUARTER_UNITS) - {1'b0, rom_angle[QUARTER_BITS-1:0]}
                      : {1'b0, rom_angle[QUARTER_BITS-1:0]};
   assign scaled_off  = RIDX_W'(quarter_off) * RIDX_W'(SINE_TABLE_DEPTH);
   assign rom_idx     = scaled_off[QUARTER_BITS +: IDX_W];

   assign rom_sv    = rom_neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});
   assign prod30    = prod_ff[ACC_W-1:0];
   assign acc_shift = acc_ff >>> PRODUCT_SHIFT;
   assign sum_y     = acc_ff + prod30;
   assign sum_shift = sum_y >>> PRODUCT_SHIFT;
   assign zoom_in   = TRIG_W'(ZOOM_BASE) + trunc15(prod_ff);
   assign size_x    = clamp_size(cfg.frame_width);
   assign size_y    = clamp_size(cfg.frame_height);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_AMPL: begin
            mul_a = MUL_W'(ZOOM_AMPL);
            mul_b = MUL_W'(rom_sv);
         end
         OP_MUL_COS: begin
            mul_a = MUL_W'(zoom_ff);
            mul_b = MUL_W'(cos_ff);
         end
         OP_MUL_SIN: begin
            mul_a = MUL_W'(zoom_ff);
            mul_b = MUL_W'(rom_sv);
         end
         OP_MUL_XC: begin
            mul_a = $signed({{(MUL_W - COORD_IN_W){1'b0}}, x_ff});
            mul_b = MUL_W'(c_ff);
         end
         OP_MUL_YS: begin
            mul_a = $signed({{(MUL_W - COORD_IN_W){1'b0}}, y_ff});
            mul_b = MUL_W'(s_ff);
         end
         OP_MUL_XS: begin
            mul_a = $signed({{(MUL_W - COORD_IN_W){1'b0}}, x_ff});
            mul_b = MUL_W'(s_ff);
         end
         OP_MUL_YC: begin
            mul_a = $signed({{(MUL_W - COORD_IN_W){1'b0}}, y_ff});
            mul_b = MUL_W'(c_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rom_ff     <= sine_rom[rom_idx];
      rom_neg_ff <= rom_angle[ANGLE_W-1];
      prod_ff    <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            x_ff    <= req_tdata[COORD_IN_W-1:0];
            y_ff    <= req_tdata[2*COORD_IN_W-1:COORD_IN_W];
            last_ff <= req_tlast;
         end
         OP_ZOOM: begin
            zoom_ff <= zoom_in;
            cos_ff  <= rom_sv;
         end
         OP_MUL_SIN: c_ff   <= trunc15(prod_ff);
         OP_MUL_XC:  s_ff   <= trunc15(prod_ff);
         OP_MUL_YS:  acc_ff <= prod30;
         OP_MUL_XS:  acc_ff <= acc_ff + prod30;
         OP_MUL_YC: begin
            ox_ff  <= acc_shift[COORD_W-1:0];
            acc_ff <= -prod30;
         end
         OP_SUM_Y:   oy_ff <= sum_shift[COORD_W-1:0];
         OP_WRAP: begin
            ox_ff <= wrap_pass(ox_ff, size_x);
            oy_ff <= wrap_pass(oy_ff, size_y);
         end
         OP_EMIT: begin
            rsp_x_ff    <= saturate(ox_ff, size_x);
            rsp_y_ff    <= saturate(oy_ff, size_y);
            rsp_last_ff <= last_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_angle_ff <= '0;
         zoom_angle_ff   <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         if (cmd.op == OP_LOAD && req_tuser) begin
            rotate_angle_ff <= cfg.start_rotate_angle;
            zoom_angle_ff   <= cfg.start_zoom_angle;
         end else if (cmd.op == OP_EMIT && last_ff) begin
            rotate_angle_ff <= rotate_angle_ff + unsigned'(cfg.rotate_step);
            zoom_angle_ff   <= zoom_angle_ff + unsigned'(cfg.zoom_step);
         end
         if (cmd.op == OP_EMIT) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_tdata       = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast       = rsp_last_ff;

endmodule

// File: sv/rotozoom_source_address.sv
// One pixel at a time: a new pixel is taken only after the last result has been emitted.
// Each pixel passes through ten steps on the single shared multiplier and sine table port,
// followed by one wrap pass per cycle; the emit step waits while the previous result is
// still held at the output and not yet taken.
// Reset is synchronous and active high; it restores the register defaults and
// clears both angles to zero, with no clearing pass.
module rotozoom_source_address #(
   parameter int MAX_DIM          = rsz_pkg::MAX_DIM_DEFAULT,
   parameter int SINE_TABLE_DEPTH = rsz_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int WRAP_PASSES      = rsz_pkg::WRAP_PASSES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pixel_x [11:0], pixel_y [23:12]
   input  logic [rsz_pkg::REQ_DATA_W-1:0] req_tdata,
   // restart [0]
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // source_x [11:0], source_y [23:12]
   output logic [rsz_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rsz_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rsz_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rsz_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rsz_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   rsz_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsz_ctrl #(
      .WRAP_PASSES (WRAP_PASSES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsz_dp #(
      .MAX_DIM          (MAX_DIM),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sv/rsz_checker.sv
module rsz_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rsz_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           csr_pready
);

   // A stalled result holds its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // One pixel at a time: the input closes right after a word is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after an accepted word");

   // A new result never appears in the cycle right after a pixel is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early after an accepted word");

   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind rotozoom_source_address rsz_checker u_rsz_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

// File: verif/source_address_checker.sv
`timescale 1ns / 1ps
module source_address_checker
   import rsz_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // pixel_x [11:0], pixel_y [23:12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // restart [0]
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // source_x [11:0], source_y [23:12]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    pending_words,
   output int                    mismatch_count
);

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [COORD_IN_W-1:0] source_x;
      logic [COORD_IN_W-1:0] source_y;
      logic                  box_done;
   } address_word_type;

   int                 sine_quarter [0:SINE_TABLE_DEPTH_DEFAULT];
   cfg_type            settings;
   logic [ANGLE_W-1:0] rotate_angle;
   logic [ANGLE_W-1:0] zoom_angle;
   address_word_type   expected_addresses [$];
   address_word_type   observed;
   address_word_type   predicted;
   int                 mismatches = 0;

   // Quarter-wave sine table in Q1.15, built from a fixed-point Taylor series.
   initial begin
      u64_type theta, t2, term, rounded, k;
      longint  sum;
      for (int i = 0; i <= SINE_TABLE_DEPTH_DEFAULT; i++) begin
         theta = (u64_type'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH_DEFAULT;
         t2 = (theta * theta) >> 30;
         term = theta;
         sum = theta;
         k = 1;
         while (term != 0 && k < 20) begin
            term = ((term * t2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
            k++;
         end
         if (sum < 0) sum = 0;
         rounded = (u64_type'(sum) + 16384) >> SCALE_SHIFT;
         sine_quarter[i] = (rounded > 32767) ? 32767 : int'(rounded);
      end
   end

   function automatic int sine_of(input logic [ANGLE_W-1:0] angle);
      u64_type offset;
      u64_type entry;
      int      magnitude;
      if (angle[ANGLE_W-2]) offset = QUARTER_UNITS - angle[QUARTER_BITS-1:0];
      else offset = angle[QUARTER_BITS-1:0];
      entry = (offset * SINE_TABLE_DEPTH_DEFAULT) >> QUARTER_BITS;
      if (entry > SINE_TABLE_DEPTH_DEFAULT) entry = SINE_TABLE_DEPTH_DEFAULT;
      magnitude = sine_quarter[entry];
      return angle[ANGLE_W-1] ? -magnitude : magnitude;
   endfunction

   // Product with a Q1.15 sine, truncated toward zero.
   function automatic int scale_by_sine(input int m, input int sine);
      longint product;
      product = longint'(m) * sine;
      if (product < 0) return -int'((-product) >>> SCALE_SHIFT);
      return int'(product >>> SCALE_SHIFT);
   endfunction

   function automatic longint frame_extent(input logic [FRAME_W-1:0] size);
      if (size < 2) return 2;
      if (size > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return size;
   endfunction

   function automatic logic [COORD_IN_W-1:0] wrap_into(input longint v, input longint extent);
      for (int p = 0; p < WRAP_PASSES_DEFAULT; p++) begin
         if (v < 0) v += extent;
         else if (v >= extent) v -= extent;
      end
      if (v < 0) v = 0;
      if (v >= extent) v = extent - 1;
      return v[COORD_IN_W-1:0];
   endfunction

   function automatic address_word_type map_pixel(input logic [COORD_IN_W-1:0] px, py,
                                                  input logic last, restart);
      int               zoom, cos_term, sin_term;
      longint           x, y, ox, oy;
      address_word_type w;
      if (restart) begin
         rotate_angle = settings.start_rotate_angle;
         zoom_angle   = settings.start_zoom_angle;
      end
      zoom     = ZOOM_BASE + scale_by_sine(ZOOM_AMPL, sine_of(zoom_angle));
      cos_term = scale_by_sine(zoom, sine_of(ANGLE_W'(rotate_angle + QUARTER_UNITS)));
      sin_term = scale_by_sine(zoom, sine_of(rotate_angle));
      x = px;
      y = py;
      ox = (x * cos_term + y * sin_term) >>> PRODUCT_SHIFT;
      oy = (y * cos_term - x * sin_term) >>> PRODUCT_SHIFT;
      w.source_x = wrap_into(ox, frame_extent(settings.frame_width));
      w.source_y = wrap_into(oy, frame_extent(settings.frame_height));
      w.box_done = last;
      if (last) begin
         rotate_angle = rotate_angle + settings.rotate_step;
         zoom_angle   = zoom_angle + settings.zoom_step;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings.frame_width        = FRAME_WIDTH_RESET;
         settings.frame_height       = FRAME_HEIGHT_RESET;
         settings.rotate_step        = '0;
         settings.zoom_step          = '0;
         settings.start_rotate_angle = '0;
         settings.start_zoom_angle   = '0;
         rotate_angle = '0;
         zoom_angle   = '0;
         expected_addresses.delete();
         pending_words  <= 0;
         mismatch_count <= mismatches;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_FRAME_WIDTH:  settings.frame_width        = csr_pwdata[FRAME_W-1:0];
               REG_FRAME_HEIGHT: settings.frame_height       = csr_pwdata[FRAME_W-1:0];
               REG_ROTATE_STEP:  settings.rotate_step        = csr_pwdata[ANGLE_W-1:0];
               REG_ZOOM_STEP:    settings.zoom_step          = csr_pwdata[ANGLE_W-1:0];
               REG_START_ROTATE: settings.start_rotate_angle = csr_pwdata[ANGLE_W-1:0];
               REG_START_ZOOM:   settings.start_zoom_angle   = csr_pwdata[ANGLE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_addresses.push_back(map_pixel(req_tdata[COORD_IN_W-1:0],
                                                   req_tdata[2*COORD_IN_W-1:COORD_IN_W],
                                                   req_tlast, req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            observed.source_x = rsp_tdata[COORD_IN_W-1:0];
            observed.source_y = rsp_tdata[2*COORD_IN_W-1:COORD_IN_W];
            observed.box_done = rsp_tlast;
            if (expected_addresses.size() == 0) begin
               $error("Result word with no expectation waiting: source_x %0d, source_y %0d",
                      observed.source_x, observed.source_y);
               mismatches++;
            end else begin
               predicted = expected_addresses.pop_front();
               if (observed.source_x !== predicted.source_x) begin
                  $error("source_x: expected %0d, actual %0d",
                         predicted.source_x, observed.source_x);
                  mismatches++;
               end
               if (observed.source_y !== predicted.source_y) begin
                  $error("source_y: expected %0d, actual %0d",
                         predicted.source_y, observed.source_y);
                  mismatches++;
               end
               if (observed.box_done !== predicted.box_done) begin
                  $error("box_done: expected %0d, actual %0d",
                         predicted.box_done, observed.box_done);
                  mismatches++;
               end
            end
         end
         pending_words  <= expected_addresses.size();
         mismatch_count <= mismatches;
      end
   end

endmodule

// File: verif/tb_rotozoom_source_address.sv
`timescale 1ns / 1ps
module tb_rotozoom_source_address;
   import rsz_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // pixel_x [11:0], pixel_y [23:12]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // restart [0]
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // source_x [11:0], source_y [23:12]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    pending_words;
   int                    mismatch_count;
   bit                    sender_burst = 1'b0;
   int                    idle_cycles = 0;

   rotozoom_source_address DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   source_address_checker address_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_pixel(input logic [COORD_IN_W-1:0] x, y, input logic last, restart);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tuser  <= restart;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic csr_write(input reg_index_type reg_index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic write_settings(input logic [FRAME_W-1:0] width, height,
                                 input logic [ANGLE_W-1:0] rotate_step, zoom_step,
                                 input logic [ANGLE_W-1:0] start_rotate, start_zoom);
      csr_write(REG_FRAME_WIDTH, CSR_DATA_W'(width));
      csr_write(REG_FRAME_HEIGHT, CSR_DATA_W'(height));
      csr_write(REG_ROTATE_STEP, CSR_DATA_W'(rotate_step));
      csr_write(REG_ZOOM_STEP, CSR_DATA_W'(zoom_step));
      csr_write(REG_START_ROTATE, CSR_DATA_W'(start_rotate));
      csr_write(REG_START_ZOOM, CSR_DATA_W'(start_zoom));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [FRAME_W-1:0] random_size();
      case ($urandom_range(0, 7))
         0: return FRAME_W'($urandom_range(0, 1));
         1: return FRAME_W'($urandom_range(4097, 8191));
         2: return FRAME_W'(MAX_DIM_DEFAULT);
         3: return FRAME_W'(2);
         4, 5: return FRAME_W'($urandom_range(3, 64));
         default: return FRAME_W'($urandom_range(65, 4096));
      endcase
   endfunction

   function automatic logic [ANGLE_W-1:0] random_step();
      if ($urandom_range(0, 3) == 0) return ANGLE_W'($urandom_range(0, 32) - 16);
      return ANGLE_W'($urandom);
   endfunction

   // Angles near the quadrant boundaries are drawn often.
   function automatic logic [ANGLE_W-1:0] random_angle();
      if ($urandom_range(0, 3) == 0)
         return ANGLE_W'($urandom_range(0, 3) * QUARTER_UNITS + $urandom_range(0, 2) - 1);
      return ANGLE_W'($urandom);
   endfunction

   initial begin
      int                    sent, bw, bh;
      logic [COORD_IN_W-1:0] x0, y0;
      bit                    restart_first, paused;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_pixel(12'd0, 12'd0, 1'b0, 1'b0);
      send_pixel(12'd4095, 12'd4095, 1'b0, 1'b0);
      send_pixel(12'd4095, 12'd0, 1'b1, 1'b0);
      send_pixel(12'd0, 12'd4095, 1'b0, 1'b1);
      send_pixel(12'd2048, 12'd2048, 1'b1, 1'b1);
      send_pixel(12'd1, 12'd1, 1'b0, 1'b0);
      wait_drained();

      // Width below and height above the legal range; the most negative rotation step.
      write_settings(13'd1, 13'd8191, 14'h2000, 14'h1fff, 14'h3fff, 14'd4096);
      send_pixel(12'd0, 12'd0, 1'b0, 1'b1);
      send_pixel(12'd4095, 12'd4095, 1'b1, 1'b0);
      send_pixel(12'd4095, 12'd4095, 1'b1, 1'b0);
      send_pixel(12'd1234, 12'd3000, 1'b0, 1'b0);
      send_pixel(12'd4095, 12'd0, 1'b1, 1'b1);
      send_pixel(12'd0, 12'd4095, 1'b0, 1'b0);
      send_pixel(12'd2047, 12'd2048, 1'b1, 1'b0);
      send_pixel(12'd4095, 12'd4095, 1'b0, 1'b1);
      wait_drained();

      write_settings(13'd4096, 13'd2, 14'd1, 14'h3fff, 14'd8192, 14'd12288);
      send_pixel(12'd4095, 12'd4095, 1'b0, 1'b1);
      send_pixel(12'd0, 12'd0, 1'b1, 1'b0);
      send_pixel(12'd4095, 12'd1, 1'b1, 1'b0);
      send_pixel(12'd1, 12'd4095, 1'b1, 1'b1);
      send_pixel(12'd3071, 12'd17, 1'b0, 1'b0);
      send_pixel(12'd4095, 12'd4095, 1'b1, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         write_settings(random_size(), random_size(), random_step(), random_step(),
                        random_angle(), random_angle());
         sent = 0;
         while (sent < 100) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
               // A box scanned row by row, the last pixel marked.
               bw = $urandom_range(1, 6);
               bh = $urandom_range(1, 6);
               x0 = COORD_IN_W'($urandom);
               y0 = COORD_IN_W'($urandom);
               restart_first = $urandom_range(0, 1);
               for (int row = 0; row < bh; row++) begin
                  for (int col = 0; col < bw; col++) begin
                     send_pixel(COORD_IN_W'(x0 + col), COORD_IN_W'(y0 + row),
                                row == bh - 1 && col == bw - 1,
                                restart_first && row == 0 && col == 0);
                     sent++;
                  end
               end
            end else begin
               repeat ($urandom_range(1, 4)) begin
                  send_pixel(COORD_IN_W'($urandom), COORD_IN_W'($urandom),
                             $urandom_range(0, 1), $urandom_range(0, 1));
                  sent++;
               end
            end
            if (phase == 2 && sent >= 50 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // The receiver stalls once for a long stretch so that the block backs up into its input.
   initial begin
      int gap;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0) steady = ($urandom_range(0, 2) == 0);
         if (taken == 300) gap = 500;
         else gap = steady ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule
